// ===== sv/hcitfg_pkg.sv =====
package hcitfg_pkg;

  typedef enum logic [2:0] {
    OP_ACQUIRE = 3'd0,
    OP_RELEASE = 3'd1,
    OP_SEND    = 3'd2,
    OP_REPLY   = 3'd3,
    OP_POOL    = 3'd4,
    OP_ACL_ACK = 3'd5
  } op_t;

  localparam logic [7:0]  PKT_COMMAND      = 8'h01;
  localparam logic [7:0]  PKT_ACL          = 8'h02;
  localparam logic [7:0]  PKT_EVENT        = 8'h04;
  localparam logic [7:0]  EVT_CMD_COMPLETE = 8'h0e;
  localparam logic [7:0]  EVT_CMD_STATUS   = 8'h0f;
  localparam logic [15:0] OPC_NONE         = 16'h0000;
  localparam logic [15:0] OPC_RESERVED     = 16'h0c35;
  localparam logic [7:0]  STATUS_PENDING   = 8'hff;

  localparam logic [16:0] FRAME_MAX     = 17'd260;
  localparam logic [16:0] CMD_HDR_LEN   = 17'd4;
  localparam logic [16:0] ACL_HDR_LEN   = 17'd5;
  localparam logic [16:0] EVT_HDR_LEN   = 17'd3;
  localparam logic [16:0] REPLY_MIN_LEN = 17'd7;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // state-independent classification of one item
  typedef struct packed {
    logic [2:0]  op;
    logic        cmd_ok;
    logic        acl_ok;
    logic        len_bad;
    logic [10:0] dlen;
    logic        reply_bad;
    logic [15:0] reply_opc;
    logic [7:0]  reply_status;
    logic [15:0] cmd_opc;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        deliver;
    logic [10:0] deliver_length;
    logic        return_buffer;
    logic        command_done;
    logic [7:0]  last_status;
    logic        fault_flag;
    logic        owned_flag;
  } result_t;

endpackage

// ===== sv/hcitfg_front.sv =====
module hcitfg_front
  import hcitfg_pkg::*;
(
  input  logic [2:0]  operation,
  input  logic [7:0]  header_byte_0,
  input  logic [7:0]  header_byte_1,
  input  logic [7:0]  header_byte_2,
  input  logic [7:0]  header_byte_3,
  input  logic [7:0]  header_byte_4,
  input  logic [7:0]  header_byte_5,
  input  logic [7:0]  header_byte_6,
  input  logic [15:0] frame_length,
  output item_t       item
);

  logic [16:0] flen;
  logic [16:0] acl_len;
  logic [16:0] evt_len;
  logic [16:0] len;
  logic        flen_ok;
  logic        complete;
  logic [15:0] cmd_opc;

  always_comb begin
    flen    = {1'b0, frame_length};
    acl_len = ACL_HDR_LEN + {1'b0, header_byte_4, header_byte_3};
    evt_len = EVT_HDR_LEN + {9'd0, header_byte_2};
    cmd_opc = {header_byte_2, header_byte_1};
    flen_ok = (flen >= CMD_HDR_LEN) && (flen <= FRAME_MAX);

    if (header_byte_0 == PKT_EVENT) begin
      len = evt_len;
    end else if (header_byte_0 == PKT_ACL) begin
      len = acl_len;
    end else begin
      len = '0;
    end

    complete = (header_byte_1 == EVT_CMD_COMPLETE);

    item.op      = operation;
    item.cmd_ok  = flen_ok && (header_byte_0 == PKT_COMMAND)
                   && (flen == CMD_HDR_LEN + {9'd0, header_byte_3})
                   && (cmd_opc != OPC_NONE) && (cmd_opc != OPC_RESERVED);
    item.acl_ok  = flen_ok && (header_byte_0 == PKT_ACL) && (flen >= ACL_HDR_LEN)
                   && (flen == acl_len);
    item.len_bad = (len == '0) || (len > FRAME_MAX);
    item.dlen    = len[10:0];
    item.reply_bad = (header_byte_0 != PKT_EVENT)
                     || (!complete && (header_byte_1 != EVT_CMD_STATUS))
                     || (len < REPLY_MIN_LEN);
    item.reply_opc    = complete ? {header_byte_5, header_byte_4}
                                 : {header_byte_6, header_byte_5};
    item.reply_status = complete ? header_byte_6 : header_byte_3;
    item.cmd_opc      = cmd_opc;
  end

endmodule

// ===== sv/hcitfg_queue.sv =====
module hcitfg_queue
  import hcitfg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue read while empty");

  a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count lost track of a pop");

endmodule

// ===== sv/hcitfg_back.sv =====
module hcitfg_back
  import hcitfg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic        is_owned_r, is_owned_nxt;
  logic        has_started_r, has_started_nxt;
  logic        has_fault_r, has_fault_nxt;
  logic        cmd_busy_r, cmd_busy_nxt;
  logic        acl_busy_r, acl_busy_nxt;
  logic [15:0] awaited_r, awaited_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        out_valid_r;
  result_t     out_res_r, res_nxt;
  logic        is_pool;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    is_owned_nxt    = is_owned_r;
    has_started_nxt = has_started_r;
    has_fault_nxt   = has_fault_r;
    cmd_busy_nxt    = cmd_busy_r;
    acl_busy_nxt    = acl_busy_r;
    awaited_nxt     = awaited_r;
    status_nxt      = status_r;
    res_nxt         = '0;
    is_pool         = (op_t'(q_item.op) == OP_POOL);

    case (op_t'(q_item.op))
      OP_ACQUIRE: begin
        if (!is_owned_r && !(has_started_r && has_fault_r)) begin
          acl_busy_nxt    = 1'b0;
          cmd_busy_nxt    = 1'b0;
          awaited_nxt     = OPC_NONE;
          status_nxt      = STATUS_PENDING;
          has_fault_nxt   = 1'b0;
          has_started_nxt = 1'b1;
          is_owned_nxt    = 1'b1;
          res_nxt.accepted = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (is_owned_r) begin
          is_owned_nxt     = 1'b0;
          has_fault_nxt    = 1'b0;
          res_nxt.accepted = 1'b1;
        end
      end
      OP_SEND: begin
        if (is_owned_r && !has_fault_r) begin
          if (q_item.cmd_ok && !cmd_busy_r) begin
            cmd_busy_nxt     = 1'b1;
            awaited_nxt      = q_item.cmd_opc;
            status_nxt       = STATUS_PENDING;
            res_nxt.accepted = 1'b1;
          end else if (q_item.acl_ok && !acl_busy_r) begin
            acl_busy_nxt     = 1'b1;
            res_nxt.accepted = 1'b1;
          end
        end
      end
      OP_REPLY, OP_POOL: begin
        if (!is_owned_r) begin
          res_nxt.return_buffer = is_pool;
        end else if (q_item.len_bad) begin
          has_fault_nxt         = 1'b1;
          res_nxt.return_buffer = is_pool;
        end else if (is_pool) begin
          res_nxt.deliver        = 1'b1;
          res_nxt.deliver_length = q_item.dlen;
          res_nxt.return_buffer  = 1'b1;
        end else if (q_item.reply_bad) begin
          has_fault_nxt = 1'b1;
        end else if (q_item.reply_opc == awaited_r) begin
          res_nxt.deliver        = 1'b1;
          res_nxt.deliver_length = q_item.dlen;
          res_nxt.command_done   = 1'b1;
          status_nxt             = q_item.reply_status;
          awaited_nxt            = OPC_NONE;
          // a match with no command outstanding is a surplus reply
          if (cmd_busy_r) begin
            cmd_busy_nxt = 1'b0;
          end else begin
            has_fault_nxt = 1'b1;
          end
        end
      end
      OP_ACL_ACK: begin
        if (is_owned_r && acl_busy_r) begin
          acl_busy_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res_nxt.last_status = status_nxt;
    res_nxt.fault_flag  = has_fault_nxt;
    res_nxt.owned_flag  = is_owned_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_owned_r    <= 1'b0;
      has_started_r <= 1'b0;
      has_fault_r   <= 1'b0;
      cmd_busy_r    <= 1'b0;
      acl_busy_r    <= 1'b0;
      awaited_r     <= OPC_NONE;
      status_r      <= STATUS_PENDING;
      out_valid_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        is_owned_r    <= is_owned_nxt;
        has_started_r <= has_started_nxt;
        has_fault_r   <= has_fault_nxt;
        cmd_busy_r    <= cmd_busy_nxt;
        acl_busy_r    <= acl_busy_nxt;
        awaited_r     <= awaited_nxt;
        status_r      <= status_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= res_nxt;
    end
  end

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.command_done) |-> out_res_r.deliver)
    else $error("command done without delivered reply");

  a_acquire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && op_t'(q_item.op) == OP_ACQUIRE && !is_owned_r
     && !(has_started_r && has_fault_r))
    |=> is_owned_r && !cmd_busy_r && !acl_busy_r && status_r == STATUS_PENDING)
    else $error("acquire left stale state");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && op_t'(q_item.op) == OP_RELEASE && is_owned_r)
    |=> !is_owned_r && !has_fault_r)
    else $error("release kept ownership or fault");

  a_deliver_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.deliver)
    |-> out_res_r.deliver_length >= EVT_HDR_LEN[10:0]
        && {6'd0, out_res_r.deliver_length} <= FRAME_MAX)
    else $error("delivered length out of range");

endmodule

// ===== sv/hci_transport_flow_gate.sv =====
// host-side hci transport gate: ownership, command/acl credits, event framing
// in channel: in_valid/in_ready with the operation, seven header bytes and the
// frame length of a send; each item gives exactly one result item
// out channel: out_valid/out_ready with the flags, delivered length, latched
// command status and the ownership and fault state after the item
// the front classifies the header (lengths, types, opcodes) with no state and
// writes a 2-entry queue; the back applies the item to the credit and
// ownership state and loads the output register
// result path: an accepted item is written to the queue, then popped into the output
// register
// throughput: one item per cycle; in_ready drops only when the queue is full,
// i.e. two items wait behind a result the receiver has not taken
// a stalled receiver freezes the output register and the back; the front keeps
// taking items until the queue fills
// reset: not owned, no fault, both credits free, status 255, queue empty,
// no result pending; no clearing pass
module hci_transport_flow_gate
  import hcitfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_header_byte_0,
  input  logic [7:0]  in_header_byte_1,
  input  logic [7:0]  in_header_byte_2,
  input  logic [7:0]  in_header_byte_3,
  input  logic [7:0]  in_header_byte_4,
  input  logic [7:0]  in_header_byte_5,
  input  logic [7:0]  in_header_byte_6,
  input  logic [15:0] in_frame_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_deliver,
  output logic [10:0] out_deliver_length,
  output logic        out_return_buffer,
  output logic        out_command_done,
  output logic [7:0]  out_last_status,
  output logic        out_fault_flag,
  output logic        out_owned_flag
);

  item_t   fr_item;
  item_t   q_item;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  logic    push;
  result_t res;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  hcitfg_front u_front (
    .operation     (in_operation),
    .header_byte_0 (in_header_byte_0),
    .header_byte_1 (in_header_byte_1),
    .header_byte_2 (in_header_byte_2),
    .header_byte_3 (in_header_byte_3),
    .header_byte_4 (in_header_byte_4),
    .header_byte_5 (in_header_byte_5),
    .header_byte_6 (in_header_byte_6),
    .frame_length  (in_frame_length),
    .item          (fr_item)
  );

  hcitfg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (fr_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  hcitfg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_accepted       = res.accepted;
  assign out_deliver        = res.deliver;
  assign out_deliver_length = res.deliver_length;
  assign out_return_buffer  = res.return_buffer;
  assign out_command_done   = res.command_done;
  assign out_last_status    = res.last_status;
  assign out_fault_flag     = res.fault_flag;
  assign out_owned_flag     = res.owned_flag;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import hcitfg_pkg::*;
();

  localparam int unsigned RUN_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 1050;

  typedef struct packed {
    op_t         op;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  b4;
    logic [7:0]  b5;
    logic [7:0]  b6;
    logic [15:0] flen;
  } gate_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_operation;
  logic [7:0]  in_header_byte_0;
  logic [7:0]  in_header_byte_1;
  logic [7:0]  in_header_byte_2;
  logic [7:0]  in_header_byte_3;
  logic [7:0]  in_header_byte_4;
  logic [7:0]  in_header_byte_5;
  logic [7:0]  in_header_byte_6;
  logic [15:0] in_frame_length;
  logic        out_valid;
  logic        out_ready;
  logic        out_accepted;
  logic        out_deliver;
  logic [10:0] out_deliver_length;
  logic        out_return_buffer;
  logic        out_command_done;
  logic [7:0]  out_last_status;
  logic        out_fault_flag;
  logic        out_owned_flag;

  // predicted transport state
  logic        owned;
  logic        started;
  logic        faulted;
  logic        cmd_busy;
  logic        acl_busy;
  logic [15:0] awaited_opc;
  logic [7:0]  status_latch;

  result_t     results_due[$];
  result_t     want;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_hold;

  hci_transport_flow_gate i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_header_byte_0   (in_header_byte_0),
    .in_header_byte_1   (in_header_byte_1),
    .in_header_byte_2   (in_header_byte_2),
    .in_header_byte_3   (in_header_byte_3),
    .in_header_byte_4   (in_header_byte_4),
    .in_header_byte_5   (in_header_byte_5),
    .in_header_byte_6   (in_header_byte_6),
    .in_frame_length    (in_frame_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_deliver        (out_deliver),
    .out_deliver_length (out_deliver_length),
    .out_return_buffer  (out_return_buffer),
    .out_command_done   (out_command_done),
    .out_last_status    (out_last_status),
    .out_fault_flag     (out_fault_flag),
    .out_owned_flag     (out_owned_flag)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver: switches between always ready, random, sparse and long stalls
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(40, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: out_ready <= (cycle_count[1:0] == 2'd0);
      default: begin
        if (rx_hold == 0) begin
          out_ready <= ~out_ready;
          rx_hold   <= $urandom_range(1, 8);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result item with none due", 1, 0);
      end else begin
        want = results_due.pop_front();
        if (out_accepted !== want.accepted)
          report_mismatch("accepted", out_accepted, want.accepted);
        if (out_deliver !== want.deliver)
          report_mismatch("deliver", out_deliver, want.deliver);
        if (out_deliver_length !== want.deliver_length)
          report_mismatch("deliver_length", out_deliver_length, want.deliver_length);
        if (out_return_buffer !== want.return_buffer)
          report_mismatch("return_buffer", out_return_buffer, want.return_buffer);
        if (out_command_done !== want.command_done)
          report_mismatch("command_done", out_command_done, want.command_done);
        if (out_last_status !== want.last_status)
          report_mismatch("last_status", out_last_status, want.last_status);
        if (out_fault_flag !== want.fault_flag)
          report_mismatch("fault_flag", out_fault_flag, want.fault_flag);
        if (out_owned_flag !== want.owned_flag)
          report_mismatch("owned_flag", out_owned_flag, want.owned_flag);
      end
    end
  end

  // applies one item to the predicted gate state and returns its result item
  task automatic predict_gate(input gate_item_t it, output result_t r);
    int unsigned frame_len;
    int unsigned acl_len;
    logic [15:0] opc;
    logic        complete;
    r = '0;
    acl_len = 5 + {it.b4, it.b3};
    frame_len = 0;
    if (it.b0 == PKT_EVENT)
      frame_len = 3 + it.b2;
    else if (it.b0 == PKT_ACL)
      frame_len = acl_len;
    case (it.op)
      OP_ACQUIRE: begin
        if (!owned && !(started && faulted)) begin
          acl_busy     = 1'b0;
          cmd_busy     = 1'b0;
          awaited_opc  = OPC_NONE;
          status_latch = STATUS_PENDING;
          faulted      = 1'b0;
          started      = 1'b1;
          owned        = 1'b1;
          r.accepted   = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (owned) begin
          owned      = 1'b0;
          faulted    = 1'b0;
          r.accepted = 1'b1;
        end
      end
      OP_SEND: begin
        if (owned && !faulted && it.flen >= 4 && it.flen <= FRAME_MAX) begin
          if (it.b0 == PKT_COMMAND && it.flen == 4 + it.b3) begin
            opc = {it.b2, it.b1};
            if (opc != OPC_RESERVED && opc != OPC_NONE && !cmd_busy) begin
              cmd_busy     = 1'b1;
              awaited_opc  = opc;
              status_latch = STATUS_PENDING;
              r.accepted   = 1'b1;
            end
          end else if (it.b0 == PKT_ACL && it.flen == acl_len) begin
            if (!acl_busy) begin
              acl_busy   = 1'b1;
              r.accepted = 1'b1;
            end
          end
        end
      end
      OP_REPLY, OP_POOL: begin
        if (!owned) begin
          r.return_buffer = (it.op == OP_POOL);
        end else if (frame_len == 0 || frame_len > FRAME_MAX) begin
          faulted = 1'b1;
          r.return_buffer = (it.op == OP_POOL);
        end else if (it.op == OP_POOL) begin
          r.deliver        = 1'b1;
          r.deliver_length = frame_len[10:0];
          r.return_buffer  = 1'b1;
        end else begin
          complete = (it.b1 == EVT_CMD_COMPLETE);
          if (it.b0 != PKT_EVENT || (!complete && it.b1 != EVT_CMD_STATUS) ||
              frame_len < REPLY_MIN_LEN) begin
            faulted = 1'b1;
          end else begin
            opc = complete ? {it.b5, it.b4} : {it.b6, it.b5};
            // a stale opcode is dropped with no effect
            if (opc == awaited_opc) begin
              r.deliver        = 1'b1;
              r.deliver_length = frame_len[10:0];
              status_latch     = complete ? it.b6 : it.b3;
              awaited_opc      = OPC_NONE;
              if (cmd_busy)
                cmd_busy = 1'b0;
              else
                faulted = 1'b1;
              r.command_done = 1'b1;
            end
          end
        end
      end
      OP_ACL_ACK: begin
        if (owned && acl_busy)
          acl_busy = 1'b0;
      end
      default: ;
    endcase
    r.last_status = status_latch;
    r.fault_flag  = faulted;
    r.owned_flag  = owned;
  endtask

  function automatic gate_item_t make_item(op_t op, logic [7:0] b0, logic [7:0] b1,
                                           logic [7:0] b2, logic [7:0] b3,
                                           logic [7:0] b4, logic [7:0] b5,
                                           logic [7:0] b6, logic [15:0] flen);
    gate_item_t it;
    it.op = op;
    it.b0 = b0;
    it.b1 = b1;
    it.b2 = b2;
    it.b3 = b3;
    it.b4 = b4;
    it.b5 = b5;
    it.b6 = b6;
    it.flen = flen;
    return it;
  endfunction

  // called at a rising edge; leaves valid high so a following item goes back to back
  task automatic send_item(input gate_item_t it);
    result_t r;
    in_valid         <= 1'b1;
    in_operation     <= it.op;
    in_header_byte_0 <= it.b0;
    in_header_byte_1 <= it.b1;
    in_header_byte_2 <= it.b2;
    in_header_byte_3 <= it.b3;
    in_header_byte_4 <= it.b4;
    in_header_byte_5 <= it.b5;
    in_header_byte_6 <= it.b6;
    in_frame_length  <= it.flen;
    do @(posedge clk); while (!in_ready);
    predict_gate(it, r);
    results_due.push_back(r);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic test_ownership();
    send_item(make_item(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_POOL, PKT_EVENT, 8'h13, 8'h05, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ACL_ACK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ACQUIRE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ACQUIRE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                        16'hffff));
  endtask

  task automatic test_command_credit();
    send_item(make_item(OP_SEND, PKT_COMMAND, 8'h35, 8'h0c, 0, 0, 0, 0, 16'd4));
    send_item(make_item(OP_SEND, PKT_COMMAND, 8'h00, 8'h00, 0, 0, 0, 0, 16'd4));
    send_item(make_item(OP_SEND, PKT_COMMAND, 8'h03, 8'h10, 8'h02, 0, 0, 0, 16'd6));
    // credit already taken
    send_item(make_item(OP_SEND, PKT_COMMAND, 8'h01, 8'h10, 0, 0, 0, 0, 16'd4));
    send_item(make_item(OP_REPLY, PKT_EVENT, EVT_CMD_COMPLETE, 8'h04, 8'h01, 8'h01,
                        8'h10, 8'h00, 0));
    send_item(make_item(OP_REPLY, PKT_EVENT, EVT_CMD_COMPLETE, 8'h04, 8'h01, 8'h03,
                        8'h10, 8'h00, 0));
    send_item(make_item(OP_SEND, PKT_COMMAND, 8'hff, 8'hff, 8'hff, 0, 0, 0, 16'd259));
    send_item(make_item(OP_REPLY, PKT_EVENT, EVT_CMD_STATUS, 8'h04, 8'h0c, 8'h01,
                        8'hff, 8'hff, 0));
    // no command outstanding, opcode zero matches the cleared opcode
    send_item(make_item(OP_REPLY, PKT_EVENT, EVT_CMD_STATUS, 8'h04, 8'h00, 0, 0, 0, 0));
    send_item(make_item(OP_SEND, PKT_ACL, 0, 0, 0, 0, 0, 0, 16'd5));
    send_item(make_item(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ACQUIRE, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_acl_credit();
    send_item(make_item(OP_SEND, PKT_ACL, 0, 0, 8'h10, 8'h00, 0, 0, 16'd21));
    send_item(make_item(OP_SEND, PKT_ACL, 0, 0, 8'h10, 8'h00, 0, 0, 16'd21));
    send_item(make_item(OP_ACL_ACK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_SEND, PKT_ACL, 0, 0, 8'hff, 8'h00, 0, 0, 16'd260));
    send_item(make_item(OP_SEND, PKT_COMMAND, 8'h01, 8'h00, 0, 0, 0, 0, 16'd3));
    send_item(make_item(OP_SEND, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                        16'hffff));
  endtask

  task automatic test_event_framing();
    send_item(make_item(OP_POOL, PKT_EVENT, 8'h3e, 8'hff, 0, 0, 0, 0, 0));
    send_item(make_item(OP_POOL, PKT_ACL, 0, 0, 8'hff, 8'h00, 0, 0, 0));
    send_item(make_item(OP_POOL, PKT_ACL, 0, 0, 8'h00, 8'h01, 0, 0, 0));
    send_item(make_item(OP_POOL, 8'h00, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ACQUIRE, 0, 0, 0, 0, 0, 0, 0, 0));
    // reply framed as acl, wrong code, too short
    send_item(make_item(OP_REPLY, PKT_ACL, EVT_CMD_COMPLETE, 0, 8'h02, 0, 0, 0, 0));
    send_item(make_item(OP_REPLY, PKT_EVENT, 8'h10, 8'h04, 0, 0, 0, 0, 0));
    send_item(make_item(OP_REPLY, PKT_EVENT, EVT_CMD_COMPLETE, 8'h03, 0, 0, 0, 0, 0));
  endtask

  task automatic draw_traffic_item(output gate_item_t it);
    int unsigned sel;
    logic [15:0] opc;
    logic        complete;
    it.op   = op_t'($urandom_range(0, 5));
    it.b0   = 8'($urandom);
    it.b1   = 8'($urandom);
    it.b2   = 8'($urandom);
    it.b3   = 8'($urandom);
    it.b4   = 8'($urandom);
    it.b5   = 8'($urandom);
    it.b6   = 8'($urandom);
    it.flen = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (!owned && sel < 60) begin
      it.op = OP_ACQUIRE;
    end else if (sel < 5) begin
      it.op = OP_RELEASE;
    end else if (sel < 30) begin
      it.op = OP_SEND;
      it.b0 = PKT_COMMAND;
      case ($urandom_range(0, 9))
        0: opc = OPC_RESERVED;
        1: opc = OPC_NONE;
        default: opc = 16'($urandom);
      endcase
      {it.b2, it.b1} = opc;
      if ($urandom_range(0, 3) != 0)
        it.b3 = 8'($urandom_range(0, 16));
      it.flen = 16'(4 + it.b3);
      if ($urandom_range(0, 9) == 0)
        it.flen = it.flen ^ (16'd1 << $urandom_range(0, 15));
    end else if (sel < 45) begin
      it.op = OP_SEND;
      it.b0 = PKT_ACL;
      if ($urandom_range(0, 3) != 0)
        it.b3 = 8'($urandom_range(0, 40));
      if ($urandom_range(0, 7) != 0)
        it.b4 = 8'h00;
      it.flen = 16'(5 + {it.b4, it.b3});
      if ($urandom_range(0, 9) == 0)
        it.flen = it.flen ^ (16'd1 << $urandom_range(0, 15));
    end else if (sel < 72) begin
      it.op = OP_REPLY;
      if ($urandom_range(0, 9) != 0)
        it.b0 = PKT_EVENT;
      complete = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) != 0)
        it.b1 = complete ? EVT_CMD_COMPLETE : EVT_CMD_STATUS;
      if ($urandom_range(0, 4) != 0)
        it.b2 = 8'($urandom_range(4, 40));
      opc = ($urandom_range(0, 9) < 7) ? awaited_opc : 16'($urandom);
      if (it.b1 == EVT_CMD_COMPLETE)
        {it.b5, it.b4} = opc;
      else
        {it.b6, it.b5} = opc;
    end else if (sel < 87) begin
      it.op = OP_POOL;
      if ($urandom_range(0, 3) != 0) begin
        it.b0 = PKT_EVENT;
      end else begin
        it.b0 = PKT_ACL;
        if ($urandom_range(0, 1) != 0)
          it.b4 = 8'h00;
      end
    end else if (sel < 94) begin
      it.op = OP_ACL_ACK;
    end
  endtask

  task automatic test_random_traffic();
    gate_item_t  it;
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        draw_traffic_item(it);
        send_item(it);
        sent++;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_operation     <= OP_ACQUIRE;
    in_header_byte_0 <= 8'h00;
    in_header_byte_1 <= 8'h00;
    in_header_byte_2 <= 8'h00;
    in_header_byte_3 <= 8'h00;
    in_header_byte_4 <= 8'h00;
    in_header_byte_5 <= 8'h00;
    in_header_byte_6 <= 8'h00;
    in_frame_length  <= 16'h0000;
    out_ready        <= 1'b0;
    rx_mode          = 0;
    rx_mode_left     = 0;
    rx_hold          = 0;
    cycle_count      = 0;
    mismatch_count   = 0;
    owned            = 1'b0;
    started          = 1'b0;
    faulted          = 1'b0;
    cmd_busy         = 1'b0;
    acl_busy         = 1'b0;
    awaited_opc      = OPC_NONE;
    status_latch     = STATUS_PENDING;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ownership();
    test_command_credit();
    test_acl_credit();
    test_event_framing();
    test_random_traffic();

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
